// ===== hw/rtl/pdk_pkg.sv =====
// Shared types, constants and the arctangent table for the planar drone step.
// Used by every module of the block; depends on nothing.
`default_nettype none

package pdk_pkg;

  // Datapath widths
  localparam int CW = 34;  // rotation unit x/y
  localparam int AW = 36;  // rotation unit angle, Q.30 radians
  localparam int MW = 34;  // shared multiplier operand
  localparam int PW = 68;  // shared multiplier product

  localparam int CORDIC_STEPS = 16;

  localparam logic signed [CW-1:0] CORDIC_START = 34'sd652032874;
  localparam logic signed [AW-1:0] PI_Q30       = 36'sd3373259426;
  localparam logic signed [AW-1:0] HALF_PI_Q30  = 36'sd1686629713;

  // Heading limits, Q3.13
  localparam logic signed [17:0] HEAD_PI = 18'sd25736;

  // Configuration register indexes and reset values
  localparam logic [2:0]  CFG_GAIN     = 3'd0;
  localparam logic [2:0]  CFG_MIN_STEP = 3'd1;
  localparam logic [15:0] GAIN_RST     = 16'd1256;
  localparam logic [15:0] MIN_STEP_RST = 16'd262;

  // Multiply/apply steps of one tick, in order
  typedef enum logic [3:0] {
    ST_P0, ST_P1, ST_P2, ST_TG, ST_FC, ST_LS,
    ST_VX, ST_LC, ST_FS, ST_VY, ST_VZ, ST_HD
  } step_e;

  localparam step_e ST_LAST = ST_HD;

  // Controller to datapath
  typedef struct packed {
    logic  cmd_load;
    logic  tick_load;
    logic  cord_start;
    logic  cord_half;
    logic  mul_en;
    logic  apply_en;
    step_e step;
    logic  emit;
  } pdk_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cord_done;
  } pdk_stat_t;

  // atan(2^-i) in Q.30
  function automatic logic signed [AW-1:0] atan_q30(input logic [3:0] i);
    logic signed [AW-1:0] r;
    case (i)
      4'd0:    r = 36'sd843314856;
      4'd1:    r = 36'sd497837829;
      4'd2:    r = 36'sd263043836;
      4'd3:    r = 36'sd133525158;
      4'd4:    r = 36'sd67021686;
      4'd5:    r = 36'sd33543515;
      4'd6:    r = 36'sd16775850;
      4'd7:    r = 36'sd8388437;
      4'd8:    r = 36'sd4194282;
      4'd9:    r = 36'sd2097149;
      4'd10:   r = 36'sd1048575;
      4'd11:   r = 36'sd524287;
      4'd12:   r = 36'sd262143;
      4'd13:   r = 36'sd131071;
      4'd14:   r = 36'sd65535;
      default: r = 36'sd32767;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pdk_cordic.sv =====
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Depends on pdk_pkg for widths, constants and the arctangent table.
`default_nettype none

module pdk_cordic import pdk_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic signed [AW-1:0] angle_i,
  output logic                      done_o,
  output logic signed [15:0]        sin_o,
  output logic signed [15:0]        cos_o
);

  logic signed [CW-1:0] x_q, x_d, y_q, y_d;
  logic signed [AW-1:0] ang_q, ang_d;
  logic signed [AW-1:0] fold_ang;
  logic                 fold_neg, neg_q;
  logic [3:0]           idx_q;
  logic                 busy_q, fin_q, done_q;
  logic signed [15:0]   sin_q, cos_q;
  logic signed [CW-1:0] xs, ys, xn, yn, xr, yr;

  // Bring the angle into +-pi/2
  always_comb begin
    fold_ang = angle_i;
    fold_neg = 1'b0;
    if (angle_i > HALF_PI_Q30) begin
      fold_ang = angle_i - PI_Q30;
      fold_neg = 1'b1;
    end else if (angle_i < -HALF_PI_Q30) begin
      fold_ang = angle_i + PI_Q30;
      fold_neg = 1'b1;
    end
  end

  // One micro-rotation
  always_comb begin
    xs = x_q >>> idx_q;
    ys = y_q >>> idx_q;
    if (ang_q >= 0) begin
      x_d   = x_q - ys;
      y_d   = y_q + xs;
      ang_d = ang_q - atan_q30(idx_q);
    end else begin
      x_d   = x_q + ys;
      y_d   = y_q - xs;
      ang_d = ang_q + atan_q30(idx_q);
    end
  end

  // Undo the fold, round Q.30 to Q1.15
  always_comb begin
    xn = neg_q ? -x_q : x_q;
    yn = neg_q ? -y_q : y_q;
    xr = (xn + 34'sd16384) >>> 15;
    yr = (yn + 34'sd16384) >>> 15;
  end

  function automatic logic signed [15:0] clamp_unit(input logic signed [CW-1:0] v);
    logic signed [15:0] r;
    if (v > 34'sd32767)       r = 16'sd32767;
    else if (v < -34'sd32767) r = -16'sd32767;
    else                      r = v[15:0];
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
      neg_q  <= 1'b0;
      x_q    <= '0;
      y_q    <= '0;
      ang_q  <= '0;
      sin_q  <= '0;
      cos_q  <= '0;
    end else begin
      done_q <= 1'b0;
      fin_q  <= 1'b0;
      if (start_i) begin
        x_q    <= CORDIC_START;
        y_q    <= '0;
        ang_q  <= fold_ang;
        neg_q  <= fold_neg;
        idx_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        x_q   <= x_d;
        y_q   <= y_d;
        ang_q <= ang_d;
        idx_q <= idx_q + 4'd1;
        if (idx_q == 4'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        cos_q  <= clamp_unit(xr);
        sin_q  <= clamp_unit(yr);
        done_q <= 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign sin_o  = sin_q;
  assign cos_o  = cos_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pdk_datapath.sv =====
// State registers, shared multiplier and output word of the drone step.
// Depends on pdk_pkg and instantiates pdk_cordic.
`default_nettype none

module pdk_datapath import pdk_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic signed [15:0] cmd_forward_i,
  input  wire logic signed [15:0] cmd_lateral_i,
  input  wire logic signed [15:0] cmd_vertical_i,
  input  wire logic signed [15:0] cmd_yaw_rate_i,
  input  wire logic [15:0]        elapsed_i,
  input  wire pdk_cmd_t           cmd_i,
  output pdk_stat_t               stat_o,
  output logic signed [31:0]      pos_x_o,
  output logic signed [31:0]      pos_y_o,
  output logic signed [31:0]      pos_z_o,
  output logic signed [15:0]      quat_w_o,
  output logic signed [15:0]      quat_z_o
);

  logic [15:0]          gain_q, min_step_q, t_q;
  logic signed [31:0]   pos_q [3];
  logic signed [31:0]   vel_q [3];
  logic signed [15:0]   heading_q;
  logic signed [15:0]   cf_q, cl_q, cv_q, cy_q;
  logic [32:0]          tg_q;
  logic signed [32:0]   acc_q;
  logic signed [PW-1:0] prod_q, prod_d;
  logic signed [MW-1:0] ma, mb, t_op;
  logic signed [PW-1:0] r13, r16, r36;
  logic signed [33:0]   r13_s, r16_s, r36_s;
  logic signed [17:0]   h_sum, h_new;
  logic signed [AW-1:0] cord_ang;
  logic signed [15:0]   cord_sin, cord_cos;
  logic                 cord_done;
  logic signed [31:0]   out_x_q, out_y_q, out_z_q;
  logic signed [15:0]   out_w_q, out_z_rot_q;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647)       r = 32'sh7fffffff;
    else if (v < -34'sd2147483648) r = 32'sh80000000;
    else                           r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [33:0] sext32(input logic signed [31:0] v);
    return {{2{v[31]}}, v};
  endfunction

  // Rotation unit angle: old heading, or half of the new heading
  assign cord_ang = cmd_i.cord_half ? {{4{heading_q[15]}}, heading_q, 16'b0}
                                    : {{3{heading_q[15]}}, heading_q, 17'b0};

  pdk_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.cord_start),
    .angle_i (cord_ang),
    .done_o  (cord_done),
    .sin_o   (cord_sin),
    .cos_o   (cord_cos)
  );

  assign stat_o.cord_done = cord_done;

  // Shared multiplier operand select
  assign t_op = $signed({18'b0, t_q});
  always_comb begin
    ma = t_op;
    mb = '0;
    unique case (cmd_i.step)
      ST_P0: mb = {{2{vel_q[0][31]}}, vel_q[0]};
      ST_P1: mb = {{2{vel_q[1][31]}}, vel_q[1]};
      ST_P2: mb = {{2{vel_q[2][31]}}, vel_q[2]};
      ST_TG: mb = $signed({18'b0, gain_q});
      ST_FC: begin ma = {{18{cf_q[15]}}, cf_q}; mb = {{18{cord_cos[15]}}, cord_cos}; end
      ST_LS: begin ma = {{18{cl_q[15]}}, cl_q}; mb = {{18{cord_sin[15]}}, cord_sin}; end
      ST_LC: begin ma = {{18{cl_q[15]}}, cl_q}; mb = {{18{cord_cos[15]}}, cord_cos}; end
      ST_FS: begin ma = {{18{cf_q[15]}}, cf_q}; mb = {{18{cord_sin[15]}}, cord_sin}; end
      ST_VX, ST_VY: begin ma = {acc_q[32], acc_q}; mb = $signed({1'b0, tg_q}); end
      ST_VZ: mb = {{18{cv_q[15]}}, cv_q};
      ST_HD: mb = {{18{cy_q[15]}}, cy_q};
      default: mb = '0;
    endcase
  end

  assign prod_d = ma * mb;

  // Round to nearest, ties up
  assign r13   = (prod_q + 68'sd4096) >>> 13;
  assign r16   = (prod_q + 68'sd32768) >>> 16;
  assign r36   = (prod_q + 68'sd34359738368) >>> 36;
  assign r13_s = $signed(r13[33:0]);
  assign r16_s = $signed(r16[33:0]);
  assign r36_s = $signed(r36[33:0]);

  // Heading advance with wrap snap
  always_comb begin
    h_sum = {{2{heading_q[15]}}, heading_q} + $signed(r16[17:0]);
    if (h_sum > HEAD_PI)       h_new = -HEAD_PI;
    else if (h_sum < -HEAD_PI) h_new = HEAD_PI;
    else                       h_new = h_sum;
  end

  // Configuration; writes to other indexes are ignored, reset restores defaults
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q     <= GAIN_RST;
      min_step_q <= MIN_STEP_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_GAIN)     gain_q     <= cfg_data_i[15:0];
      if (cfg_idx_i == CFG_MIN_STEP) min_step_q <= cfg_data_i[15:0];
    end
  end

  // Model state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
      end
      heading_q <= '0;
      cf_q      <= '0;
      cl_q      <= '0;
      cv_q      <= '0;
      cy_q      <= '0;
    end else begin
      if (cmd_i.cmd_load) begin
        cf_q <= cmd_forward_i;
        cl_q <= cmd_lateral_i;
        cv_q <= cmd_vertical_i;
        cy_q <= cmd_yaw_rate_i;
      end
      if (cmd_i.apply_en) begin
        case (cmd_i.step)
          ST_P0: pos_q[0] <= sat32(sext32(pos_q[0]) + r16_s);
          ST_P1: pos_q[1] <= sat32(sext32(pos_q[1]) + r16_s);
          ST_P2: pos_q[2] <= sat32(sext32(pos_q[2]) + r16_s);
          ST_VX: vel_q[0] <= sat32(sext32(vel_q[0]) + r36_s);
          ST_VY: vel_q[1] <= sat32(sext32(vel_q[1]) + r36_s);
          ST_VZ: vel_q[2] <= sat32(sext32(vel_q[2]) + r13_s);
          ST_HD: heading_q <= h_new[15:0];
          default: ;
        endcase
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_load) begin
      t_q <= (elapsed_i < min_step_q) ? min_step_q : elapsed_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.apply_en) begin
      case (cmd_i.step)
        ST_TG:        tg_q  <= prod_q[32:0];
        ST_FC, ST_LC: acc_q <= $signed(prod_q[32:0]);
        ST_LS:        acc_q <= acc_q - $signed(prod_q[32:0]);
        ST_FS:        acc_q <= acc_q + $signed(prod_q[32:0]);
        default: ;
      endcase
    end
  end

  // Output word
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_x_q     <= pos_q[0];
      out_y_q     <= pos_q[1];
      out_z_q     <= pos_q[2];
      out_w_q     <= cord_cos;
      out_z_rot_q <= cord_sin;
    end
  end

  assign pos_x_o  = out_x_q;
  assign pos_y_o  = out_y_q;
  assign pos_z_o  = out_z_q;
  assign quat_w_o = out_w_q;
  assign quat_z_o = out_z_rot_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pdk_ctrl.sv =====
// Sequencer of the drone step: handshakes, rotation passes, multiply steps.
// Depends on pdk_pkg for the command and status structs.
`default_nettype none

module pdk_ctrl import pdk_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire logic      kind_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output pdk_cmd_t       cmd_o,
  input  wire pdk_stat_t stat_i
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CORD_A = 7'b0000010,
    S_MUL    = 7'b0000100,
    S_APPLY  = 7'b0001000,
    S_LAUNCH = 7'b0010000,
    S_CORD_B = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  step_e  step_q, step_d;
  logic   out_valid_q, out_valid_d;
  logic   in_acc;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cmd_o       = '0;
    cmd_o.step  = step_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (kind_i) begin
            cmd_o.tick_load  = 1'b1;
            cmd_o.cord_start = 1'b1;
            state_d          = S_CORD_A;
          end else begin
            cmd_o.cmd_load = 1'b1;
          end
        end
      end
      S_CORD_A: begin
        if (stat_i.cord_done) begin
          step_d  = ST_P0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_APPLY;
      end
      S_APPLY: begin
        cmd_o.apply_en = 1'b1;
        if (step_q == ST_LAST) begin
          state_d = S_LAUNCH;
        end else begin
          step_d  = step_e'(step_q + 4'd1);
          state_d = S_MUL;
        end
      end
      // heading register holds the new value from here on
      S_LAUNCH: begin
        cmd_o.cord_start = 1'b1;
        cmd_o.cord_half  = 1'b1;
        state_d          = S_CORD_B;
      end
      S_CORD_B: begin
        cmd_o.cord_half = 1'b1;
        if (stat_i.cord_done) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= ST_P0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // Output word is never overwritten while still waiting
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (!out_valid_q || out_ready_i))
    else $error("result word overwritten while pending");

  // Rotation results only arrive while waiting for them
  a_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.cord_done |-> (state_q == S_CORD_A || state_q == S_CORD_B))
    else $error("unexpected rotation done");

  // Step index stays within the schedule
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL || state_q == S_APPLY) |-> (step_q <= ST_LAST))
    else $error("step index out of range");

  // A tick always leads into the first rotation pass
  a_tick_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && kind_i) |=> (state_q == S_CORD_A))
    else $error("tick did not start rotation");

endmodule

`default_nettype wire

// ===== hw/rtl/planar_drone_kinematics_step.sv =====
// Planar drone kinematics step, top level: controller plus datapath.
// Depends on pdk_pkg, pdk_ctrl and pdk_datapath.
//
// Input channel (valid/ready): one word per item. kind 0 stores the four
// commands and gives no result. kind 1 is a time tick: it advances
// position, velocity and heading and gives one output word (positions and
// the half-heading quaternion w, z).
// A tick takes two passes of one iterative CORDIC unit plus twelve steps
// through one shared 34x34 multiplier. One item is worked on at a time.
// Output channel (valid/ready): the word sits in an output register. The
// next item is accepted while it waits; a following tick stalls only in
// its emit state until the pending word is taken.
// Configuration: write port, index 0 gain, 1 minimum step; writes to
// other indexes (start position, heading) are ignored; reset restores the
// default register values. Reset clears velocities and commands and loads
// the default start state; no result is pending after reset.
`default_nettype none

module planar_drone_kinematics_step import pdk_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               kind_i,
  input  wire logic signed [15:0] cmd_forward_i,
  input  wire logic signed [15:0] cmd_lateral_i,
  input  wire logic signed [15:0] cmd_vertical_i,
  input  wire logic signed [15:0] cmd_yaw_rate_i,
  input  wire logic [15:0]        elapsed_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      pos_x_o,
  output logic signed [31:0]      pos_y_o,
  output logic signed [31:0]      pos_z_o,
  output logic signed [15:0]      quat_w_o,
  output logic signed [15:0]      quat_z_o
);

  pdk_cmd_t  cmd;
  pdk_stat_t stat;

  pdk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  pdk_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_forward_i  (cmd_forward_i),
    .cmd_lateral_i  (cmd_lateral_i),
    .cmd_vertical_i (cmd_vertical_i),
    .cmd_yaw_rate_i (cmd_yaw_rate_i),
    .elapsed_i      (elapsed_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .pos_z_o        (pos_z_o),
    .quat_w_o       (quat_w_o),
    .quat_z_o       (quat_z_o)
  );

endmodule

`default_nettype wire
